// ===== rtl/vqds_pkg.sv =====
// Shared types and constants for the virtqueue descriptor submitter.
// No dependencies; every file of the block but vqds_ram refers to this package.
package vqds_pkg;

	localparam int QID_W   = 2;
	localparam int ADDR_W  = 64;
	localparam int LEN_W   = 32;
	localparam int FLAGS_W = 16;
	localparam int SLOT_W  = 8;
	localparam int AIDX_W  = 16;
	localparam int OFFS_W  = 8;
	localparam int LG_W    = 4;

	localparam logic [LG_W-1:0]    LG_RESET  = 4'd8;
	localparam logic [OFFS_W-1:0]  OFFS_MAX  = 8'hFF;
	localparam logic [FLAGS_W-1:0] FLAG_NEXT = 16'h0001;

	localparam logic KIND_DESC    = 1'b0;
	localparam logic KIND_PUBLISH = 1'b1;

	typedef struct packed {
		logic [QID_W-1:0]   queue_id;
		logic [ADDR_W-1:0]  buf_addr;
		logic [LEN_W-1:0]   buf_len;
		logic [FLAGS_W-1:0] buf_flags;
		logic               chain_end;
	} item_t;

	typedef struct packed {
		logic               record_kind;
		logic [SLOT_W-1:0]  ring_slot;
		logic [ADDR_W-1:0]  out_addr;
		logic [LEN_W-1:0]   out_len;
		logic [FLAGS_W-1:0] out_flags;
		logic [SLOT_W-1:0]  link_slot;
		logic               link_valid;
		logic [SLOT_W-1:0]  head_slot;
		logic [AIDX_W-1:0]  avail_index;
		logic [QID_W-1:0]   notify_queue;
		logic               last_record;
	} rec_t;

endpackage

// ===== rtl/vqds_ifs.sv =====
// Handshake channel interfaces: descriptor input, record output, config write.
// Depends on vqds_pkg for field widths.
interface vqds_desc_if;
	logic                             valid;
	logic                             ready;
	logic [vqds_pkg::QID_W-1:0]       queue_id;
	logic [vqds_pkg::ADDR_W-1:0]      buf_addr;
	logic [vqds_pkg::LEN_W-1:0]       buf_len;
	logic [vqds_pkg::FLAGS_W-1:0]     buf_flags;
	logic                             chain_end;
	modport source (output valid, queue_id, buf_addr, buf_len, buf_flags, chain_end,
		input ready);
	modport sink (input valid, queue_id, buf_addr, buf_len, buf_flags, chain_end,
		output ready);
endinterface

interface vqds_rec_if;
	logic                             valid;
	logic                             ready;
	logic                             record_kind;
	logic [vqds_pkg::SLOT_W-1:0]      ring_slot;
	logic [vqds_pkg::ADDR_W-1:0]      out_addr;
	logic [vqds_pkg::LEN_W-1:0]       out_len;
	logic [vqds_pkg::FLAGS_W-1:0]     out_flags;
	logic [vqds_pkg::SLOT_W-1:0]      link_slot;
	logic                             link_valid;
	logic [vqds_pkg::SLOT_W-1:0]      head_slot;
	logic [vqds_pkg::AIDX_W-1:0]      avail_index;
	logic [vqds_pkg::QID_W-1:0]       notify_queue;
	logic                             last_record;
	modport source (output valid, record_kind, ring_slot, out_addr, out_len, out_flags,
		link_slot, link_valid, head_slot, avail_index, notify_queue, last_record,
		input ready);
	modport sink (input valid, record_kind, ring_slot, out_addr, out_len, out_flags,
		link_slot, link_valid, head_slot, avail_index, notify_queue, last_record,
		output ready);
endinterface

interface vqds_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [vqds_pkg::LG_W-1:0]   queue_size_log2;
	modport source (output valid, queue_size_log2, input ready);
	modport sink (input valid, queue_size_log2, output ready);
endinterface

// ===== rtl/vqds_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module vqds_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/vqds_update.sv =====
// Per-queue read-modify-write arithmetic: descriptor and publish records and
// the queue state to write back. Depends on vqds_pkg.
module vqds_update #(
	parameter int SW = 8
) (
	input  vqds_pkg::item_t                 item,
	input  logic [vqds_pkg::LG_W-1:0]       size_log2,
	input  logic                            publish,
	input  logic [SW-1:0]                   cur_wslot,
	input  logic [SW-1:0]                   cur_head,
	input  logic [vqds_pkg::OFFS_W-1:0]     cur_offs,
	input  logic [vqds_pkg::AIDX_W-1:0]     cur_avail,
	output logic [SW-1:0]                   nxt_wslot,
	output logic [SW-1:0]                   nxt_head,
	output logic [vqds_pkg::OFFS_W-1:0]     nxt_offs,
	output logic [vqds_pkg::AIDX_W-1:0]     nxt_avail,
	output vqds_pkg::rec_t                  rec
);

	logic [vqds_pkg::LG_W-1:0] lg;
	logic [SW:0]               mask_w;
	logic [SW-1:0]             mask;
	logic [SW-1:0]             slot;
	logic [SW-1:0]             slot_inc;
	logic [SW-1:0]             head;
	logic [vqds_pkg::AIDX_W-1:0] avail_inc;

	always_comb begin
		// clamp oversized rings to the largest supported size
		lg = (32'(size_log2) > SW) ? vqds_pkg::LG_W'(SW) : size_log2;
		mask_w = ((SW + 1)'(1) << lg) - (SW + 1)'(1);
		mask = mask_w[SW-1:0];
		slot = cur_wslot & mask;
		slot_inc = (slot + SW'(1)) & mask;
		head = (cur_offs == '0) ? slot : cur_head;
		avail_inc = cur_avail + vqds_pkg::AIDX_W'(1);

		nxt_wslot = slot_inc;
		nxt_head = head;
		if (item.chain_end) begin
			nxt_offs = '0;
			nxt_avail = avail_inc;
		end else begin
			nxt_offs = (cur_offs == vqds_pkg::OFFS_MAX) ? cur_offs
				: cur_offs + vqds_pkg::OFFS_W'(1);
			nxt_avail = cur_avail;
		end

		rec = '0;
		if (publish) begin
			rec.record_kind = vqds_pkg::KIND_PUBLISH;
			rec.ring_slot = vqds_pkg::SLOT_W'(cur_avail[SW-1:0] & mask);
			rec.head_slot = vqds_pkg::SLOT_W'(head & mask);
			rec.avail_index = avail_inc;
			rec.notify_queue = item.queue_id;
			rec.last_record = 1'b1;
		end else begin
			rec.record_kind = vqds_pkg::KIND_DESC;
			rec.ring_slot = vqds_pkg::SLOT_W'(slot);
			rec.out_addr = item.buf_addr;
			rec.out_len = item.buf_len;
			if (item.chain_end) begin
				rec.out_flags = item.buf_flags;
			end else begin
				rec.out_flags = item.buf_flags | vqds_pkg::FLAG_NEXT;
				rec.link_slot = vqds_pkg::SLOT_W'(slot_inc);
				rec.link_valid = 1'b1;
			end
			rec.last_record = ~item.chain_end;
		end
	end

endmodule

// ===== rtl/virtqueue_descriptor_submitter_top.sv =====
// Top level of the split-virtqueue descriptor submitter.
// Depends on vqds_pkg, the channel interfaces, vqds_ram and vqds_update.
// Usage:
//   desc  - descriptor input items: queue_id, buf_addr, buf_len, buf_flags,
//           chain_end. An item with queue_id >= QUEUE_COUNT is taken and dropped.
//   rec   - result items: one descriptor-table write per descriptor, followed
//           by an avail-ring publish record after the last descriptor of a chain.
//   cfg   - write of queue_size_log2, always ready; write only while idle.
// Per-queue state (write slot, chain head, chain offset, avail counter) lives
// in one synchronous RAM of QUEUE_COUNT entries. An accepted item reads its
// queue's entry; in the next cycle the item is in stage 1, where its records
// are built and the entry is written back when the item leaves. A write to the
// entry the next item reads is forwarded into that item's stage 1.
// An item is registered into stage 1, and its records into the output register.
// Throughput: one descriptor per cycle while rec is ready; a chain-end item holds
// stage 1 for its descriptor and publish records, since the single record register moves one record per cycle.
// Reset: queue_size_log2 returns to 8 and per-entry valid bits clear, so every
// queue reads as zero state at once; no clearing pass is needed.
// Stall: when rec is not ready the output register holds, stage 1 holds, and
// desc.ready drops until stage 1 can drain.
module virtqueue_descriptor_submitter_top #(
	parameter int QUEUE_COUNT   = 4,
	parameter int MAX_RING_LOG2 = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	vqds_desc_if.sink  desc,
	vqds_rec_if.source rec,
	vqds_cfg_if.sink   cfg
);

	localparam int SW   = MAX_RING_LOG2;
	localparam int QW   = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
	localparam int OW   = vqds_pkg::OFFS_W;
	localparam int AW   = vqds_pkg::AIDX_W;
	localparam int ST_W = 2 * SW + OW + AW;

	// config register
	logic [vqds_pkg::LG_W-1:0] size_log2_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_log2_q <= vqds_pkg::LG_RESET;
		end else if (cfg.valid) begin
			size_log2_q <= cfg.queue_size_log2;
		end
	end

	// input side
	vqds_pkg::item_t in_item;
	logic            accept;
	logic            in_range;
	logic [QW-1:0]   in_qi;

	always_comb begin
		in_item.queue_id = desc.queue_id;
		in_item.buf_addr = desc.buf_addr;
		in_item.buf_len = desc.buf_len;
		in_item.buf_flags = desc.buf_flags;
		in_item.chain_end = desc.chain_end;
	end

	assign in_range = (32'(desc.queue_id) < QUEUE_COUNT);
	assign in_qi = QW'(desc.queue_id);
	assign accept = desc.valid && desc.ready;

	// stage 1 and output register control
	logic            s1_valid_q;
	logic            phase_q;
	vqds_pkg::item_t item_s1;
	logic [QW-1:0]   qi_s1;
	logic            rvld_s1;
	logic            fwd_hit_s1;
	logic [ST_W-1:0] fwd_s1;
	logic            out_valid_q;
	vqds_pkg::rec_t  rec_q;

	logic out_load;
	logic push;
	logic s1_done;

	assign out_load = !out_valid_q || rec.ready;
	assign push = s1_valid_q && out_load;
	// the item leaves once its last record is pushed
	assign s1_done = push && (phase_q || !item_s1.chain_end);
	assign desc.ready = !s1_valid_q || s1_done;

	// state memory and valid bits
	logic [ST_W-1:0]        ram_rdata;
	logic [ST_W-1:0]        wr_data;
	logic                   wr_en;
	logic [QUEUE_COUNT-1:0] vld_q;

	assign wr_en = s1_done;

	vqds_ram #(
		.WIDTH (ST_W),
		.DEPTH (QUEUE_COUNT)
	) u_state_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (qi_s1),
		.wdata (wr_data),
		.re    (accept),
		.raddr (in_qi),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[qi_s1] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= in_range;
			end else if (s1_done) begin
				s1_valid_q <= 1'b0;
			end
			// advance to the publish record after the descriptor of a chain end
			if (s1_done) begin
				phase_q <= 1'b0;
			end else if (push) begin
				phase_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_item;
			qi_s1 <= in_qi;
			rvld_s1 <= vld_q[in_qi];
			// forward the write-back that lands in the same edge as the read
			fwd_hit_s1 <= wr_en && (qi_s1 == in_qi);
			fwd_s1 <= wr_data;
		end
	end

	// current state of the stage-1 queue: forwarded, stored, or reset value
	logic [ST_W-1:0] cur_state;

	always_comb begin
		if (fwd_hit_s1) begin
			cur_state = fwd_s1;
		end else if (rvld_s1) begin
			cur_state = ram_rdata;
		end else begin
			cur_state = '0;
		end
	end

	logic [SW-1:0]  nxt_wslot;
	logic [SW-1:0]  nxt_head;
	logic [OW-1:0]  nxt_offs;
	logic [AW-1:0]  nxt_avail;
	vqds_pkg::rec_t s1_rec;

	vqds_update #(
		.SW (SW)
	) u_update (
		.item      (item_s1),
		.size_log2 (size_log2_q),
		.publish   (phase_q),
		.cur_wslot (cur_state[ST_W-1 -: SW]),
		.cur_head  (cur_state[ST_W-SW-1 -: SW]),
		.cur_offs  (cur_state[AW+OW-1 -: OW]),
		.cur_avail (cur_state[AW-1:0]),
		.nxt_wslot (nxt_wslot),
		.nxt_head  (nxt_head),
		.nxt_offs  (nxt_offs),
		.nxt_avail (nxt_avail),
		.rec       (s1_rec)
	);

	assign wr_data = {nxt_wslot, nxt_head, nxt_offs, nxt_avail};

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (rec.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			rec_q <= s1_rec;
		end
	end

	assign rec.valid = out_valid_q;
	assign rec.record_kind = rec_q.record_kind;
	assign rec.ring_slot = rec_q.ring_slot;
	assign rec.out_addr = rec_q.out_addr;
	assign rec.out_len = rec_q.out_len;
	assign rec.out_flags = rec_q.out_flags;
	assign rec.link_slot = rec_q.link_slot;
	assign rec.link_valid = rec_q.link_valid;
	assign rec.head_slot = rec_q.head_slot;
	assign rec.avail_index = rec_q.avail_index;
	assign rec.notify_queue = rec_q.notify_queue;
	assign rec.last_record = rec_q.last_record;

	// write-back happens only for an item in stage 1 that is leaving
	a_wr_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> s1_valid_q)
		else $error("state write-back without an item in stage 1");

	// the publish phase belongs to a chain-end item only
	a_phase_chain_end: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> (s1_valid_q && item_s1.chain_end))
		else $error("publish phase for an item that does not end a chain");

	// a new item never overtakes an item still in stage 1
	a_no_overtake: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s1_done) |=> $stable(qi_s1))
		else $error("stage 1 item replaced before it finished");

	// a forward hit comes only from a write-back in the accepting cycle
	a_fwd_source: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !(wr_en && (qi_s1 == in_qi))) |=> !fwd_hit_s1)
		else $error("forward hit without a matching write-back");

endmodule
